// ----- src/rbm_pkg.sv -----
// Shared types and constants for the RMS bar level meter.
package rbm_pkg;

	// Default number of bars the level store holds.
	localparam int MAX_BARS_DEF = 32;

	// Configuration port address width and register indexes.
	localparam int ADDR_W = 4;
	localparam logic [1:0] REG_BAR_COUNT = 2'd0;
	localparam logic [1:0] REG_KEEP      = 2'd1;
	localparam logic [1:0] REG_GAIN      = 2'd2;

	// Register reset values.
	localparam logic [5:0] BAR_COUNT_RST = 6'd32;
	localparam logic [8:0] KEEP_RST      = 9'd179;
	localparam logic [7:0] GAIN_RST      = 8'd10;

	// Fixed point constants: full keep weight (Q0.8) and level one (Q0.15).
	localparam logic [8:0]  KEEP_FULL = 9'd256;
	localparam logic [24:0] LEVEL_ONE = 25'd32768;

	// Iteration counts of the shared divider and the square root unit.
	localparam int DIV_STEPS  = 48;
	localparam int SQRT_STEPS = 16;

	// Datapath micro-operations, one per cycle.
	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_DIV_LEN,
		OP_DIV_SUM,
		OP_DIV_STEP,
		OP_FRAG_INIT,
		OP_IDX_POS,
		OP_IDX_INC,
		OP_SQ,
		OP_ACC,
		OP_SQRT_INIT,
		OP_SQRT_STEP,
		OP_GAIN_MAG,
		OP_GAIN_ROOT,
		OP_GAIN_ZERO,
		OP_MIX1,
		OP_MIX2,
		OP_EMIT,
		OP_BIN_NEXT,
		OP_ADVANCE
	} op_t;

	// Command from the controller to the datapath.
	typedef struct packed {
		op_t op;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic len_zero;
		logic pos_zero;
		logic bin_zero;
		logic pos_lt_nb;
		logic cb_lt_nb;
		logic bin_done;
		logic frag_end;
		logic idx_lt_nb;
		logic div_last;
		logic sqrt_last;
		logic out_free;
	} status_t;

endpackage

// ----- src/rbm_dp.sv -----
// Datapath of the RMS bar level meter: accumulator, divider, square root, smoothing, level store.
module rbm_dp #(
	parameter int MAX_BARS = rbm_pkg::MAX_BARS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  rbm_pkg::cmd_t       cmd,
	output rbm_pkg::status_t    status,
	input  logic signed [15:0]  sample,
	input  logic [15:0]         fragment_length,
	input  logic [5:0]          bar_count,
	input  logic [8:0]          keep_weight,
	input  logic [7:0]          gain,
	input  logic                out_ready,
	output logic                out_valid,
	output logic [4:0]          bar_index,
	output logic [15:0]         bar_level,
	output logic                final_bar
);

	localparam int BAR_W = (MAX_BARS > 1) ? $clog2(MAX_BARS) : 1;
	localparam int NB_W  = $clog2(MAX_BARS + 1);

	rbm_pkg::op_t op;

	logic [NB_W-1:0]  nb;
	logic [8:0]       keep_eff;

	// Fragment state.
	logic [15:0]      pos_q;
	logic [15:0]      bl_q;
	logic [NB_W-1:0]  cb_q;
	logic [47:0]      sum_q;
	logic [16:0]      bin_end_q;
	logic [MAX_BARS-1:0] valid_q;
	logic             out_vld_q;

	// Working registers.
	logic [16:0]      mag_q;
	logic [15:0]      len_q;
	logic [47:0]      quo_q;
	logic [15:0]      rem_q;
	logic [15:0]      dvs_q;
	logic [5:0]       cnt_q;
	logic [19:0]      sr_q;
	logic [15:0]      root_q;
	logic [33:0]      sq_q;
	logic [15:0]      norm_q;
	logic [15:0]      rd_q;
	logic             rd_vld_q;
	logic [24:0]      p_old_q;
	logic [24:0]      p_new_q;
	logic [15:0]      level_q;
	logic [15:0]      idx_q;
	logic [4:0]       out_idx_q;
	logic [15:0]      out_level_q;
	logic             out_last_q;
	logic [15:0]      mem [MAX_BARS];

	logic [BAR_W-1:0] idx_w;
	logic             gain_op;
	logic [16:0]      div_sh;
	logic [19:0]      sq_t;
	logic [19:0]      sq_trial;
	logic [16:0]      rms_sel;
	logic [24:0]      gain_prod;
	logic [15:0]      old_lvl;
	logic [25:0]      mix_sum;
	logic [16:0]      pos_inc;

	assign op = cmd.op;
	assign idx_w = idx_q[BAR_W-1:0];
	assign gain_op = (op == rbm_pkg::OP_GAIN_MAG) || (op == rbm_pkg::OP_GAIN_ROOT) ||
		(op == rbm_pkg::OP_GAIN_ZERO);

	// Bars in use, clamped to one through the store depth, and the keep weight capped at one.
	always_comb begin
		if (bar_count == 6'd0) begin
			nb = NB_W'(1);
		end else if (32'(bar_count) > 32'(MAX_BARS)) begin
			nb = NB_W'(MAX_BARS);
		end else begin
			nb = NB_W'(bar_count);
		end
		keep_eff = (keep_weight > rbm_pkg::KEEP_FULL) ? rbm_pkg::KEEP_FULL : keep_weight;
	end

	// One restoring divide step and one square root step.
	always_comb begin
		div_sh   = {rem_q, quo_q[47]};
		sq_t     = {sr_q[17:0], quo_q[31:30]};
		sq_trial = {2'b00, root_q, 2'b01};
	end

	// Gain stage, smoothing sum and position arithmetic.
	always_comb begin
		rms_sel   = (op == rbm_pkg::OP_GAIN_MAG) ? mag_q : {1'b0, root_q};
		gain_prod = 25'(rms_sel) * 25'(gain);
		old_lvl   = rd_vld_q ? rd_q : 16'd0;
		mix_sum   = 26'(p_old_q) + 26'(p_new_q);
		pos_inc   = 17'(pos_q) + 17'd1;
	end

	// Status toward the controller.
	always_comb begin
		status.len_zero  = (len_q == 16'd0);
		status.pos_zero  = (pos_q == 16'd0);
		status.bin_zero  = (bl_q == 16'd0);
		status.pos_lt_nb = (pos_q < 16'(nb));
		status.cb_lt_nb  = (cb_q < nb);
		status.bin_done  = (pos_inc == bin_end_q);
		status.frag_end  = (pos_inc >= 17'(len_q));
		status.idx_lt_nb = (idx_q < 16'(nb));
		status.div_last  = (cnt_q == 6'(rbm_pkg::DIV_STEPS - 1));
		status.sqrt_last = (cnt_q == 6'(rbm_pkg::SQRT_STEPS - 1));
		status.out_free  = !out_vld_q || out_ready;
	end

	// Fragment state and output handshake, cleared by reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			bl_q      <= '0;
			cb_q      <= '0;
			sum_q     <= '0;
			bin_end_q <= '0;
			valid_q   <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (out_vld_q && out_ready) begin
				out_vld_q <= 1'b0;
			end
			case (op)
				rbm_pkg::OP_FRAG_INIT: begin
					bl_q      <= quo_q[15:0];
					bin_end_q <= {1'b0, quo_q[15:0]};
					cb_q      <= '0;
					sum_q     <= '0;
				end
				rbm_pkg::OP_ACC: begin
					sum_q <= sum_q + 48'(sq_q);
				end
				rbm_pkg::OP_BIN_NEXT: begin
					cb_q      <= cb_q + NB_W'(1);
					sum_q     <= '0;
					bin_end_q <= bin_end_q + 17'(bl_q);
				end
				rbm_pkg::OP_EMIT: begin
					valid_q[idx_w] <= 1'b1;
					out_vld_q      <= 1'b1;
				end
				rbm_pkg::OP_ADVANCE: begin
					pos_q <= status.frag_end ? 16'd0 : pos_inc[15:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Working registers of the divider, square root and smoothing path.
	always_ff @(posedge clk) begin
		case (op)
			rbm_pkg::OP_LOAD: begin
				mag_q <= sample[15] ? (17'h10000 - {1'b0, $unsigned(sample)})
					: {1'b0, $unsigned(sample)};
				len_q <= fragment_length;
			end
			rbm_pkg::OP_DIV_LEN: begin
				quo_q <= {32'd0, len_q};
				rem_q <= '0;
				dvs_q <= 16'(nb);
				cnt_q <= '0;
			end
			rbm_pkg::OP_DIV_SUM: begin
				quo_q <= sum_q;
				rem_q <= '0;
				dvs_q <= bl_q;
				cnt_q <= '0;
				idx_q <= 16'(cb_q);
			end
			rbm_pkg::OP_DIV_STEP: begin
				if (div_sh >= {1'b0, dvs_q}) begin
					rem_q <= 16'(div_sh - {1'b0, dvs_q});
					quo_q <= {quo_q[46:0], 1'b1};
				end else begin
					rem_q <= div_sh[15:0];
					quo_q <= {quo_q[46:0], 1'b0};
				end
				cnt_q <= cnt_q + 6'd1;
			end
			rbm_pkg::OP_IDX_POS: begin
				idx_q <= pos_q;
			end
			rbm_pkg::OP_IDX_INC: begin
				idx_q <= idx_q + 16'd1;
			end
			rbm_pkg::OP_SQ: begin
				sq_q <= 34'(mag_q) * 34'(mag_q);
			end
			rbm_pkg::OP_SQRT_INIT: begin
				sr_q   <= '0;
				root_q <= '0;
				cnt_q  <= '0;
			end
			rbm_pkg::OP_SQRT_STEP: begin
				if (sq_t >= sq_trial) begin
					sr_q   <= sq_t - sq_trial;
					root_q <= {root_q[14:0], 1'b1};
				end else begin
					sr_q   <= sq_t;
					root_q <= {root_q[14:0], 1'b0};
				end
				quo_q <= {quo_q[45:0], 2'b00};
				cnt_q <= cnt_q + 6'd1;
			end
			rbm_pkg::OP_GAIN_MAG, rbm_pkg::OP_GAIN_ROOT: begin
				norm_q   <= (gain_prod > rbm_pkg::LEVEL_ONE) ? 16'h8000 : gain_prod[15:0];
				rd_vld_q <= valid_q[idx_w];
			end
			rbm_pkg::OP_GAIN_ZERO: begin
				norm_q   <= '0;
				rd_vld_q <= valid_q[idx_w];
			end
			rbm_pkg::OP_MIX1: begin
				p_old_q <= 25'(keep_eff) * 25'(old_lvl);
				p_new_q <= 25'(rbm_pkg::KEEP_FULL - keep_eff) * 25'(norm_q);
			end
			rbm_pkg::OP_MIX2: begin
				level_q <= mix_sum[23:8];
			end
			rbm_pkg::OP_EMIT: begin
				out_idx_q   <= idx_q[4:0];
				out_level_q <= level_q;
				out_last_q  <= (idx_q == 16'(nb) - 16'd1);
			end
			default: begin
			end
		endcase
	end

	// Level store: written on a beat, read ahead of the smoothing multiply.
	always_ff @(posedge clk) begin
		if (op == rbm_pkg::OP_EMIT) begin
			mem[idx_w] <= level_q;
		end
		if (gain_op) begin
			rd_q <= mem[idx_w];
		end
	end

	assign out_valid = out_vld_q;
	assign bar_index = out_idx_q;
	assign bar_level = out_level_q;
	assign final_bar = out_last_q;

endmodule

// ----- src/rbm_ctrl.sv -----
// Controller state machine of the RMS bar level meter.
module rbm_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  rbm_pkg::status_t status,
	output rbm_pkg::cmd_t    cmd
);

	typedef enum logic [19:0] {
		ST_IDLE  = 20'h00001,
		ST_CHECK = 20'h00002,
		ST_DIVL  = 20'h00004,
		ST_FINIT = 20'h00008,
		ST_DISP  = 20'h00010,
		ST_SQ    = 20'h00020,
		ST_ACC   = 20'h00040,
		ST_DSUM  = 20'h00080,
		ST_DIVS  = 20'h00100,
		ST_SQI   = 20'h00200,
		ST_SQRT  = 20'h00400,
		ST_GAIN  = 20'h00800,
		ST_MIX1  = 20'h01000,
		ST_MIX2  = 20'h02000,
		ST_EMIT  = 20'h04000,
		ST_AFTER = 20'h08000,
		ST_TAIL  = 20'h10000,
		ST_DECK  = 20'h20000,
		ST_ADV   = 20'h40000,
		ST_SPARE = 20'h80000
	} state_t;

	typedef enum logic [1:0] {
		KIND_BIN,
		KIND_SHORT,
		KIND_DECAY
	} kind_t;

	state_t state_q, state_d;
	kind_t  kind_q, kind_d;

	// State and kind of the level being worked on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			kind_q  <= KIND_BIN;
		end else begin
			state_q <= state_d;
			kind_q  <= kind_d;
		end
	end

	assign in_ready = (state_q == ST_IDLE);

	// Next state and datapath command.
	always_comb begin
		state_d = state_q;
		kind_d  = kind_q;
		cmd.op  = rbm_pkg::OP_NONE;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.op  = rbm_pkg::OP_LOAD;
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (status.len_zero) begin
					state_d = ST_IDLE;
				end else if (status.pos_zero) begin
					cmd.op  = rbm_pkg::OP_DIV_LEN;
					state_d = ST_DIVL;
				end else begin
					state_d = ST_DISP;
				end
			end
			ST_DIVL: begin
				cmd.op = rbm_pkg::OP_DIV_STEP;
				if (status.div_last) begin
					state_d = ST_FINIT;
				end
			end
			ST_FINIT: begin
				cmd.op  = rbm_pkg::OP_FRAG_INIT;
				state_d = ST_DISP;
			end
			ST_DISP: begin
				if (status.bin_zero) begin
					cmd.op = rbm_pkg::OP_IDX_POS;
					kind_d = KIND_SHORT;
					state_d = status.pos_lt_nb ? ST_GAIN : ST_TAIL;
				end else if (status.cb_lt_nb) begin
					kind_d  = KIND_BIN;
					state_d = ST_SQ;
				end else begin
					state_d = ST_ADV;
				end
			end
			ST_SQ: begin
				cmd.op  = rbm_pkg::OP_SQ;
				state_d = ST_ACC;
			end
			ST_ACC: begin
				cmd.op  = rbm_pkg::OP_ACC;
				state_d = status.bin_done ? ST_DSUM : ST_ADV;
			end
			ST_DSUM: begin
				cmd.op  = rbm_pkg::OP_DIV_SUM;
				state_d = ST_DIVS;
			end
			ST_DIVS: begin
				cmd.op = rbm_pkg::OP_DIV_STEP;
				if (status.div_last) begin
					state_d = ST_SQI;
				end
			end
			ST_SQI: begin
				cmd.op  = rbm_pkg::OP_SQRT_INIT;
				state_d = ST_SQRT;
			end
			ST_SQRT: begin
				cmd.op = rbm_pkg::OP_SQRT_STEP;
				if (status.sqrt_last) begin
					state_d = ST_GAIN;
				end
			end
			ST_GAIN: begin
				case (kind_q)
					KIND_SHORT: cmd.op = rbm_pkg::OP_GAIN_MAG;
					KIND_BIN:   cmd.op = rbm_pkg::OP_GAIN_ROOT;
					default:    cmd.op = rbm_pkg::OP_GAIN_ZERO;
				endcase
				state_d = ST_MIX1;
			end
			ST_MIX1: begin
				cmd.op  = rbm_pkg::OP_MIX1;
				state_d = ST_MIX2;
			end
			ST_MIX2: begin
				cmd.op  = rbm_pkg::OP_MIX2;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (status.out_free) begin
					cmd.op  = rbm_pkg::OP_EMIT;
					state_d = ST_AFTER;
				end
			end
			ST_AFTER: begin
				case (kind_q)
					KIND_BIN: begin
						cmd.op  = rbm_pkg::OP_BIN_NEXT;
						state_d = ST_ADV;
					end
					KIND_SHORT: begin
						state_d = ST_TAIL;
					end
					default: begin
						cmd.op  = rbm_pkg::OP_IDX_INC;
						state_d = ST_DECK;
					end
				endcase
			end
			ST_TAIL: begin
				// A short fragment that ends here decays every later bar.
				if (status.frag_end) begin
					cmd.op  = rbm_pkg::OP_IDX_INC;
					kind_d  = KIND_DECAY;
					state_d = ST_DECK;
				end else begin
					state_d = ST_ADV;
				end
			end
			ST_DECK: begin
				state_d = status.idx_lt_nb ? ST_GAIN : ST_ADV;
			end
			ST_ADV: begin
				cmd.op  = rbm_pkg::OP_ADVANCE;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ----- src/rms_bar_level_meter.sv -----
// Top level of the RMS bar level meter: configuration registers, stream ports, assertions.
//
// The meter takes one sample beat at a time and works on it to the end before it
// takes the next. A sample that only adds to a bin is squared and accumulated. The
// first sample of a fragment also divides the fragment length by the bar count to
// get the bin length, and a sample that closes a bin adds a divide on the shared
// restoring divider, a square root and the gain and smoothing multiplies. In a
// fragment shorter than the bar count a sample drives its own bar, and on the last
// sample each later bar decays in turn. A result beat waits in an output register,
// so the next sample is taken while it is pending; a new level is held back only
// while that register is still full.
module rms_bar_level_meter #(
	parameter int MAX_BARS = rbm_pkg::MAX_BARS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// Sample stream.
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [31:0]                s_tdata,   // [15:0] sample, [31:16] fragment_length
	// Level stream.
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [23:0]                m_tdata,   // [4:0] bar_index, [20:5] bar_level, zero pad
	output logic                       m_tlast,   // final_bar
	// Configuration port.
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [rbm_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);

	logic [5:0]       bar_count_q;
	logic [8:0]       keep_q;
	logic [7:0]       gain_q;
	logic [1:0]       reg_idx;
	rbm_pkg::cmd_t    cmd;
	rbm_pkg::status_t status;
	logic [4:0]       bar_index;
	logic [15:0]      bar_level;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bar_count_q <= rbm_pkg::BAR_COUNT_RST;
			keep_q      <= rbm_pkg::KEEP_RST;
			gain_q      <= rbm_pkg::GAIN_RST;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_idx)
				rbm_pkg::REG_BAR_COUNT: bar_count_q <= pwdata[5:0];
				rbm_pkg::REG_KEEP:      keep_q      <= pwdata[8:0];
				rbm_pkg::REG_GAIN:      gain_q      <= pwdata[7:0];
				default: begin
				end
			endcase
		end
	end

	// Register read back.
	always_comb begin
		case (reg_idx)
			rbm_pkg::REG_BAR_COUNT: prdata = {26'd0, bar_count_q};
			rbm_pkg::REG_KEEP:      prdata = {23'd0, keep_q};
			rbm_pkg::REG_GAIN:      prdata = {24'd0, gain_q};
			default:                prdata = 32'd0;
		endcase
	end

	rbm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	rbm_dp #(
		.MAX_BARS (MAX_BARS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.sample          ($signed(s_tdata[15:0])),
		.fragment_length (s_tdata[31:16]),
		.bar_count       (bar_count_q),
		.keep_weight     (keep_q),
		.gain            (gain_q),
		.out_ready       (m_tready),
		.out_valid       (m_tvalid),
		.bar_index       (bar_index),
		.bar_level       (bar_level),
		.final_bar       (m_tlast)
	);

	assign m_tdata = {3'b000, bar_level, bar_index};

`ifndef SYNTHESIS
	// A level beat never goes above one.
	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[20:5] <= 16'h8000))
		else $error("bar level above one");

	// After a sample beat is taken the meter is busy and drops s_tready.
	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("sample taken while still busy");
`endif

endmodule
